>>> hdl/skj_pkg.sv
package skj_pkg;

	localparam int BlockW = 64;
	localparam int WordW = 16;
	localparam int Rounds = 32;
	localparam int KeyHiW = 16;
	localparam int KeyLoW = 64;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_KEY_LOW = 1'b1;

	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	typedef logic [BlockW-1:0] block_t;
	typedef logic [WordW-1:0] word_t;
	typedef logic [79:0] key_t;

	localparam logic [7:0] FTAB [256] = '{
		8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
		8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
		8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
		8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
		8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
		8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
		8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
		8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
		8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
		8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
		8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
		8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
		8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
		8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
		8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
		8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
	};

	// Key byte n (0..9), byte 0 in the top bits of the 80-bit key.
	function automatic logic [7:0] key_byte(key_t key, logic [3:0] n);
		logic [6:0] sh;
		sh = 7'(8 * (9 - int'(n)));
		return key[sh +: 8];
	endfunction

	// Next key byte index, wrapping from 9 back to 0.
	function automatic logic [3:0] key_next(logic [3:0] n);
		return (n == 4'd9) ? 4'd0 : n + 4'd1;
	endfunction

	// One round on the whole block, forward or inverse direction.
	// b is the first key byte index of the round, (4 * r) mod 10.
	function automatic block_t skj_round(block_t blk, logic dec, logic [4:0] r,
		logic [3:0] b, key_t key);
		logic [15:0] w0, w1, w2, w3, t, ctr;
		logic [7:0] hi, lo, k0, k1, k2, k3;
		logic [3:0] b1, b2, b3;
		block_t res;
		w0 = blk[63:48];
		w1 = blk[47:32];
		w2 = blk[31:16];
		w3 = blk[15:0];
		ctr = 16'(r) + 16'd1;
		b1 = key_next(b);
		b2 = key_next(b1);
		b3 = key_next(b2);
		k0 = key_byte(key, b);
		k1 = key_byte(key, b1);
		k2 = key_byte(key, b2);
		k3 = key_byte(key, b3);
		if (dec == REQ_ENCRYPT) begin
			hi = w0[15:8];
			lo = w0[7:0];
			hi = hi ^ FTAB[lo ^ k0];
			lo = lo ^ FTAB[hi ^ k1];
			hi = hi ^ FTAB[lo ^ k2];
			lo = lo ^ FTAB[hi ^ k3];
			t = {hi, lo};
			if (!r[3]) res = {t ^ w3 ^ ctr, t, w1, w2};
			else res = {w3, t, w0 ^ w1 ^ ctr, w2};
		end else begin
			hi = w1[15:8];
			lo = w1[7:0];
			lo = lo ^ FTAB[hi ^ k3];
			hi = hi ^ FTAB[lo ^ k2];
			lo = lo ^ FTAB[hi ^ k1];
			hi = hi ^ FTAB[lo ^ k0];
			t = {hi, lo};
			if (!r[3]) res = {t, w2, w3, w0 ^ w1 ^ ctr};
			else res = {t, t ^ w2 ^ ctr, w3, w0};
		end
		return res;
	endfunction

endpackage

>>> hdl/skj_if.sv
interface skj_in_if import skj_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	block_t block_in;
	modport source (output valid, req_type, block_in, input ready);
	modport sink (input valid, req_type, block_in, output ready);
endinterface

interface skj_out_if import skj_pkg::*; ();
	logic valid;
	logic ready;
	block_t block_out;
	modport source (output valid, block_out, input ready);
	modport sink (input valid, block_out, output ready);
endinterface

>>> hdl/skipjack_block_cipher.sv
// Skipjack cipher engine, 64-bit block, 80-bit key.
// Channels: in_ch carries req_type (0 encrypt, 1 decrypt) and block_in;
// out_ch carries block_out. Both use valid/ready; a transfer happens on a
// rising clk edge with valid and ready high.
// Key: write key_high (index 0) and key_low (index 1) through cfg_we,
// cfg_idx, cfg_data while no block is in flight.
// Pipeline: 32 round stages, one round of the cipher per stage, each a
// four-lookup G permutation over the F table. Blocks pass the stage
// registers in order; throughput is one block per cycle without stalls.
// Output: stage 32 is the output register. On a receiver stall a full
// stage holds only if all later ones are full; in_ch.ready stays high
// while bubbles remain, so these fill before the stall reaches the input.
// Reset: arst_n clears all valid bits and both key registers to zero.
module skipjack_block_cipher import skj_pkg::*; (
	input logic clk,
	input logic arst_n,
	skj_in_if.sink in_ch,
	skj_out_if.source out_ch,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_idx,
	input logic [CfgDataW-1:0] cfg_data
);

	logic [KeyHiW-1:0] key_high_q;
	logic [KeyLoW-1:0] key_low_q;
	key_t key;
	logic vld_s [Rounds+1];
	logic dec_s [Rounds+1];
	block_t blk_s [Rounds+1];
	logic adv [1:Rounds];

	assign key = {key_high_q, key_low_q};

	// Store key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY_HIGH: key_high_q <= cfg_data[KeyHiW-1:0];
				REG_KEY_LOW: key_low_q <= cfg_data[KeyLoW-1:0];
				default: ;
			endcase
		end
	end

	// Stage i advances when it is empty or its content moves on
	always_comb begin
		adv[Rounds] = !vld_s[Rounds] || out_ch.ready;
		for (int i = Rounds - 1; i >= 1; i--) adv[i] = !vld_s[i] || adv[i+1];
	end

	assign vld_s[0] = in_ch.valid;
	assign dec_s[0] = in_ch.req_type;
	assign blk_s[0] = in_ch.block_in;
	assign in_ch.ready = adv[1];

	// Round stages: stage i applies round i-1 (encrypt) or 32-i (decrypt)
	for (genvar i = 1; i <= Rounds; i++) begin : g_stage
		localparam logic [3:0] EncKb = 4'((4 * (i - 1)) % 10);
		localparam logic [3:0] DecKb = 4'((4 * (Rounds - i)) % 10);
		logic [4:0] rnd;
		logic [3:0] kb;
		assign rnd = dec_s[i-1] ? 5'(Rounds - i) : 5'(i - 1);
		assign kb = dec_s[i-1] ? DecKb : EncKb;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i] <= 1'b0;
			else if (adv[i]) vld_s[i] <= vld_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (adv[i] && vld_s[i-1]) begin
				dec_s[i] <= dec_s[i-1];
				blk_s[i] <= skj_round(blk_s[i-1], dec_s[i-1], rnd, kb, key);
			end
		end
	end

	assign out_ch.valid = vld_s[Rounds];
	assign out_ch.block_out = blk_s[Rounds];

endmodule

>>> hdl/skj_checker.sv
module skj_checker import skj_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input block_t block_out
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_out))
		else $error("result changed while stalled");

	// Input side is open whenever output is taken
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// Nothing comes out shortly after reset
	a_no_early: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result right after reset");

	// Input stalls only when a result waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

endmodule

bind skipjack_block_cipher skj_checker u_skj_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.block_out(out_ch.block_out)
);

>>> sim/skj_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces come from the RTL (hdl/skj_if.sv); this file carries
// the key write port bundle used by the bench.
interface skj_key_port import skj_pkg::*; ();
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_data;
endinterface

>>> sim/skipjack_block_cipher_tb.sv
`timescale 1ns / 1ps
module skipjack_block_cipher_tb;
	import skj_pkg::*;

	localparam int PipeDepth = 32;
	localparam int IdleLimit = 4000;

	// Cipher predictor and queue of expected blocks.
	class cipher_board;
		logic [7:0] sbox [256];
		logic [79:0] key;
		block_t pending [$];
		int errors;

		function void load_key(logic [79:0] k);
			key = k;
		endfunction

		function logic [7:0] kb(int n);
			return key[8 * (9 - (n % 10)) +: 8];
		endfunction

		function block_t cipher(logic dec, block_t blk);
			logic [15:0] w [4];
			logic [15:0] t, c;
			logic [7:0] h, l;
			int r, b;
			for (int k = 0; k < 4; k++) w[k] = blk[48 - 16 * k +: 16];
			for (int s = 0; s < 32; s++) begin
				r = dec ? 31 - s : s;
				b = 4 * r;
				c = 16'(r + 1);
				if (!dec) begin
					h = w[0][15:8]; l = w[0][7:0];
					h ^= sbox[l ^ kb(b)];
					l ^= sbox[h ^ kb(b + 1)];
					h ^= sbox[l ^ kb(b + 2)];
					l ^= sbox[h ^ kb(b + 3)];
					t = {h, l};
					if (((r >> 3) & 1) == 0) begin
						c = t ^ w[3] ^ c;
						w[3] = w[2]; w[2] = w[1]; w[1] = t; w[0] = c;
					end else begin
						c = w[0] ^ w[1] ^ c;
						w[0] = w[3]; w[3] = w[2]; w[2] = c; w[1] = t;
					end
				end else begin
					h = w[1][15:8]; l = w[1][7:0];
					l ^= sbox[h ^ kb(b + 3)];
					h ^= sbox[l ^ kb(b + 2)];
					l ^= sbox[h ^ kb(b + 1)];
					h ^= sbox[l ^ kb(b)];
					t = {h, l};
					if (((r >> 3) & 1) == 0) begin
						c = w[0] ^ w[1] ^ c;
						w[1] = w[2]; w[2] = w[3]; w[3] = c; w[0] = t;
					end else begin
						c = t ^ w[2] ^ c;
						w[1] = c; w[2] = w[3]; w[3] = w[0]; w[0] = t;
					end
				end
			end
			return {w[0], w[1], w[2], w[3]};
		endfunction

		function void note_input(logic dec, block_t blk);
			pending.push_back(cipher(dec, blk));
		endfunction

		function void check_output(block_t got);
			block_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected block_out %h", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: block_out expected %h actual %h", $realtime, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	skj_in_if in_ch ();
	skj_out_if out_ch ();
	skj_key_port kp ();

	skipjack_block_cipher dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(kp.cfg_we), .cfg_idx(kp.cfg_idx), .cfg_data(kp.cfg_data)
	);

	always #5 clk = ~clk;

	cipher_board board;
	int idle_cycles;
	bit stall_burst;
	int stall_mode;

	initial begin
		board = new();
		foreach (FTAB[i]) board.sbox[i] = FTAB[i];
		board.load_key('0);
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_ENCRYPT;
		in_ch.block_in = '0;
		out_ch.ready = 1'b0;
		kp.cfg_we = 1'b0;
		kp.cfg_idx = REG_KEY_HIGH;
		kp.cfg_data = '0;
	end

	// Receiver stall pattern: modes switch between always ready, random, and bursty.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: begin
					out_ch.ready <= 1'b1;
				end
				1: begin
					out_ch.ready <= $urandom_range(0, 2) != 0;
				end
				default: begin
					if ($urandom_range(0, 7) == 0) stall_burst = ~stall_burst;
					out_ch.ready <= !stall_burst;
				end
			endcase
		end
	end

	// Score each transfer on both channels; watchdog on silence.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) board.note_input(in_ch.req_type, in_ch.block_in);
			if (out_ch.valid && out_ch.ready) board.check_output(out_ch.block_out);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("skipjack_block_cipher verification failed");
				$finish;
			end
		end
	end

	task automatic write_key_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		kp.cfg_we <= 1'b1;
		kp.cfg_idx <= idx;
		kp.cfg_data <= data;
		@(posedge clk);
	endtask

	// Load the full key while the pipe is empty.
	task automatic set_key(logic [79:0] k);
		write_key_reg(REG_KEY_HIGH, {48'b0, k[79:64]});
		write_key_reg(REG_KEY_LOW, k[63:0]);
		kp.cfg_we <= 1'b0;
		board.load_key(k);
	endtask

	// Offer one block and hold it until transferred.
	task automatic send_block(logic dec, block_t blk);
		in_ch.valid <= 1'b1;
		in_ch.req_type <= dec;
		in_ch.block_in <= blk;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drop_valid();
		in_ch.valid <= 1'b0;
	endtask

	function automatic block_t rand_block();
		return {$urandom(), $urandom()};
	endfunction

	// Drop valid and wait for the pipe to drain, then idle before the next phase.
	task automatic drain();
		drop_valid();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (PipeDepth + 4) @(posedge clk);
	endtask

	// Random traffic in bursts; decrypts use a ciphertext from this key about half the time.
	task automatic random_phase(int count);
		block_t known [$];
		block_t b;
		logic dec;
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && count > 0) begin
				dec = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 2) == 0) b = {$urandom_range(0, 3) == 0 ? 32'hffff_ffff : 32'h0,
					$urandom()};
				else b = rand_block();
				if (dec && known.size() != 0 && $urandom_range(0, 1)) b = known[$urandom_range(0,
					known.size() - 1)];
				if (!dec) known.push_back(board.cipher(REQ_ENCRYPT, b));
				send_block(dec, b);
				burst--;
				count--;
			end
			if ($urandom_range(0, 3) != 0) begin
				drop_valid();
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	initial begin
		logic [79:0] k;
		stall_mode = 0;
		stall_burst = 1'b0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero key from reset: extreme blocks in both directions.
		send_block(REQ_ENCRYPT, '0);
		send_block(REQ_ENCRYPT, '1);
		send_block(REQ_DECRYPT, '0);
		send_block(REQ_DECRYPT, '1);
		drain();

		// Standard known-answer vector and all-ones key.
		set_key(80'h00998877665544332211);
		send_block(REQ_ENCRYPT, 64'h33221100ddccbbaa);
		send_block(REQ_DECRYPT, 64'h2587cae27a12d300);
		send_block(REQ_ENCRYPT, 64'h8000000000000001);
		send_block(REQ_DECRYPT, 64'h0123456789abcdef);
		drain();
		set_key('1);
		send_block(REQ_ENCRYPT, '0);
		send_block(REQ_ENCRYPT, '1);
		send_block(REQ_DECRYPT, '0);
		send_block(REQ_DECRYPT, 64'haaaa5555aaaa5555);
		drain();

		// Random keys, random traffic.
		for (int ph = 0; ph < 5; ph++) begin
			k = {$urandom(), $urandom(), 16'($urandom())};
			set_key(k);
			random_phase(110);
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("skipjack_block_cipher verification clean");
		end else begin
			$display("skipjack_block_cipher verification failed");
		end
		$finish;
	end
endmodule

>>> sim.f
hdl/skj_pkg.sv
hdl/skj_if.sv
hdl/skipjack_block_cipher.sv
hdl/skj_checker.sv
sim/skj_tb_if.sv
sim/skipjack_block_cipher_tb.sv
